@@ rtl/rwpa_pkg.sv @@
`timescale 1ns / 1ps

package rwpa_pkg;

  // angle and coordinate formats
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int COORD_BITS = 32;

  // trig values are Q1.15, products Q2.30
  localparam int TRIG_BITS  = 16;
  localparam int LUT_BITS   = 8;
  localparam int PROD_BITS  = 2 * TRIG_BITS;
  localparam int PROD_FRAC  = 2 * (TRIG_BITS - 1);
  localparam int STEP_SHIFT = PROD_FRAC - FRAC_BITS;
  localparam int DELTA_BITS = PROD_BITS - STEP_SHIFT;

  // step queue and in-flight accounting
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);
  // front pipeline holds two requests ahead of the queue
  localparam int CREDITS   = QDEPTH;

  typedef logic [LUT_BITS-1:0]          lut_angle_t;
  typedef logic signed [TRIG_BITS-1:0]  trig_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [DELTA_BITS-1:0] delta_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one decoded step handed from front to back
  typedef struct packed {
    logic   restart;
    delta_t dx;
    delta_t dy;
    delta_t dz;
  } step_t;

  // queue handshake between front, queue and back
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  // quarter-wave sine, sin(k*pi/128) in Q1.15, last entry saturated
  function automatic trig_t qsin(input logic [6:0] k);
    trig_t v;
    case (k)
      7'd0:  v = 16'sd0;     7'd1:  v = 16'sd804;   7'd2:  v = 16'sd1608;
      7'd3:  v = 16'sd2411;  7'd4:  v = 16'sd3212;  7'd5:  v = 16'sd4011;
      7'd6:  v = 16'sd4808;  7'd7:  v = 16'sd5602;  7'd8:  v = 16'sd6393;
      7'd9:  v = 16'sd7180;  7'd10: v = 16'sd7962;  7'd11: v = 16'sd8740;
      7'd12: v = 16'sd9512;  7'd13: v = 16'sd10279; 7'd14: v = 16'sd11039;
      7'd15: v = 16'sd11793; 7'd16: v = 16'sd12540; 7'd17: v = 16'sd13279;
      7'd18: v = 16'sd14010; 7'd19: v = 16'sd14733; 7'd20: v = 16'sd15447;
      7'd21: v = 16'sd16151; 7'd22: v = 16'sd16846; 7'd23: v = 16'sd17531;
      7'd24: v = 16'sd18205; 7'd25: v = 16'sd18868; 7'd26: v = 16'sd19520;
      7'd27: v = 16'sd20160; 7'd28: v = 16'sd20788; 7'd29: v = 16'sd21403;
      7'd30: v = 16'sd22006; 7'd31: v = 16'sd22595; 7'd32: v = 16'sd23170;
      7'd33: v = 16'sd23732; 7'd34: v = 16'sd24279; 7'd35: v = 16'sd24812;
      7'd36: v = 16'sd25330; 7'd37: v = 16'sd25833; 7'd38: v = 16'sd26319;
      7'd39: v = 16'sd26791; 7'd40: v = 16'sd27246; 7'd41: v = 16'sd27684;
      7'd42: v = 16'sd28106; 7'd43: v = 16'sd28511; 7'd44: v = 16'sd28899;
      7'd45: v = 16'sd29269; 7'd46: v = 16'sd29622; 7'd47: v = 16'sd29957;
      7'd48: v = 16'sd30274; 7'd49: v = 16'sd30572; 7'd50: v = 16'sd30853;
      7'd51: v = 16'sd31114; 7'd52: v = 16'sd31357; 7'd53: v = 16'sd31581;
      7'd54: v = 16'sd31786; 7'd55: v = 16'sd31972; 7'd56: v = 16'sd32138;
      7'd57: v = 16'sd32286; 7'd58: v = 16'sd32413; 7'd59: v = 16'sd32522;
      7'd60: v = 16'sd32610; 7'd61: v = 16'sd32679; 7'd62: v = 16'sd32729;
      7'd63: v = 16'sd32758; 7'd64: v = 16'sd32767;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // full-turn sine from 2 quadrant bits and 6 index bits
  function automatic trig_t sin8(input lut_angle_t a);
    logic [6:0] idx;
    trig_t      v;
    idx = a[6] ? (7'd64 - {1'b0, a[5:0]}) : {1'b0, a[5:0]};
    v   = qsin(idx);
    return a[7] ? -v : v;
  endfunction

endpackage

@@ rtl/rwpa_front.sv @@
`timescale 1ns / 1ps

module rwpa_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [rwpa_pkg::ANGLE_BITS-1:0] theta_i,
  input  logic [rwpa_pkg::ANGLE_BITS-1:0] phi_i,
  input  logic                           restart_i,
  output logic                           push_o,
  output rwpa_pkg::step_t                step_o
);

  rwpa_pkg::lut_angle_t t_ang, p_ang;
  rwpa_pkg::trig_t      st_q, ct_q, sp_q, cp_q;
  logic                 rst1_q, v1_q;
  rwpa_pkg::prod_t      prod_x, prod_y, prod_z;
  rwpa_pkg::step_t      step_d, step_q;
  logic                 v2_q;

  // top bits of each angle address the sine table
  assign t_ang = theta_i[rwpa_pkg::ANGLE_BITS-1 -: rwpa_pkg::LUT_BITS];
  assign p_ang = phi_i[rwpa_pkg::ANGLE_BITS-1 -: rwpa_pkg::LUT_BITS];

  // stage 1 and stage 2 valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
    end
  end

  // stage 1: trig lookup, cosine as sine a quarter turn ahead
  always_ff @(posedge clk_i) begin
    st_q   <= rwpa_pkg::sin8(t_ang);
    ct_q   <= rwpa_pkg::sin8(t_ang + rwpa_pkg::lut_angle_t'(64));
    sp_q   <= rwpa_pkg::sin8(p_ang);
    cp_q   <= rwpa_pkg::sin8(p_ang + rwpa_pkg::lut_angle_t'(64));
    rst1_q <= restart_i;
  end

  // stage 2: Q2.30 products, floored down to the coordinate fraction
  assign prod_x = ct_q * sp_q;
  assign prod_y = st_q * sp_q;
  assign prod_z = rwpa_pkg::prod_t'(cp_q) <<< (rwpa_pkg::TRIG_BITS - 1);

  always_comb begin
    step_d.restart = rst1_q;
    step_d.dx      = rwpa_pkg::delta_t'(prod_x >>> rwpa_pkg::STEP_SHIFT);
    step_d.dy      = rwpa_pkg::delta_t'(prod_y >>> rwpa_pkg::STEP_SHIFT);
    step_d.dz      = rwpa_pkg::delta_t'(prod_z >>> rwpa_pkg::STEP_SHIFT);
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
  end

  assign push_o = v2_q;
  assign step_o = step_q;

endmodule

@@ rtl/rwpa_queue.sv @@
`timescale 1ns / 1ps

module rwpa_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rwpa_pkg::q_ctrl_t   ctrl_i,
  input  rwpa_pkg::step_t     step_i,
  output logic                empty_o,
  output rwpa_pkg::step_t     head_o
);

  rwpa_pkg::step_t                  mem_q [rwpa_pkg::QDEPTH];
  logic [rwpa_pkg::QPTR_BITS-1:0]   wr_q, rd_q;
  logic [rwpa_pkg::QCNT_BITS-1:0]   cnt_q, cnt_d;

  // pointers and fill count; credits upstream keep it from overflowing
  always_comb begin
    cnt_d = cnt_q;
    case ({ctrl_i.push, ctrl_i.pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (ctrl_i.push) wr_q <= wr_q + 1'b1;
      if (ctrl_i.pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) mem_q[wr_q] <= step_i;
  end

  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

endmodule

@@ rtl/rwpa_back.sv @@
`timescale 1ns / 1ps

module rwpa_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  rwpa_pkg::step_t     head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rwpa_pkg::coord_t    x_o,
  output rwpa_pkg::coord_t    y_o,
  output rwpa_pkg::coord_t    z_o
);

  rwpa_pkg::coord_t acc_x_q, acc_y_q, acc_z_q;
  rwpa_pkg::coord_t acc_x_d, acc_y_d, acc_z_d;
  logic             valid_q;

  // saturating add of a step delta to a coordinate
  function automatic rwpa_pkg::coord_t sat_add(input rwpa_pkg::coord_t base,
                                               input rwpa_pkg::delta_t d);
    logic signed [rwpa_pkg::COORD_BITS:0] s;
    rwpa_pkg::coord_t                    r;
    s = (rwpa_pkg::COORD_BITS + 1)'(base) + (rwpa_pkg::COORD_BITS + 1)'(d);
    if (s[rwpa_pkg::COORD_BITS] != s[rwpa_pkg::COORD_BITS-1]) begin
      r = s[rwpa_pkg::COORD_BITS] ? {1'b1, {(rwpa_pkg::COORD_BITS-1){1'b0}}}
                                  : {1'b0, {(rwpa_pkg::COORD_BITS-1){1'b1}}};
    end else begin
      r = s[rwpa_pkg::COORD_BITS-1:0];
    end
    return r;
  endfunction

  // take a step whenever the output register is free
  assign pop_o = !empty_i && (!valid_q || !out_stall_i);

  always_comb begin
    acc_x_d = sat_add(head_i.restart ? '0 : acc_x_q, head_i.dx);
    acc_y_d = sat_add(head_i.restart ? '0 : acc_y_q, head_i.dy);
    acc_z_d = sat_add(head_i.restart ? '0 : acc_z_q, head_i.dz);
  end

  // position accumulators double as the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
      acc_z_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        acc_x_q <= acc_x_d;
        acc_y_q <= acc_y_d;
        acc_z_q <= acc_z_d;
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign x_o         = acc_x_q;
  assign y_o         = acc_y_q;
  assign z_o         = acc_z_q;

endmodule

@@ rtl/random_walk_position_accumulator.sv @@
`timescale 1ns / 1ps

// 3D random-walk position accumulator.
// Input channel: in_valid_i / in_stall_o carry one step request (theta_i,
// phi_i, restart_i); a request is taken at a clock edge with valid high and
// stall low. Output channel: out_valid_o / out_stall_i carry the new
// position x_pos_o, y_pos_o, z_pos_o (signed, 16 fraction bits, saturating).
// One result per request, in order. restart_i moves the walker back to the
// origin before the step is applied.
// A taken request passes the two-stage table lookup and multiply in the
// front end, then the step queue, then the saturating add in the back end.
// Throughput: one request per cycle while in_stall_o is low; the only loop
// is that saturating add, and the front end is free of state.
// A four-entry step queue sits between front and back; in_stall_o rises
// when four requests are in flight, so a stalled receiver fills the queue
// and then holds off the sender. The result held on a stalled output does
// not change.
// Reset (rst_ni low, asynchronous) puts the position at the origin and
// empties the pipeline and queue; no clearing pass is needed.

module random_walk_position_accumulator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rwpa_pkg::ANGLE_BITS-1:0] theta_i,
  input  logic [rwpa_pkg::ANGLE_BITS-1:0] phi_i,
  input  logic                            restart_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rwpa_pkg::COORD_BITS-1:0] x_pos_o,
  output logic [rwpa_pkg::COORD_BITS-1:0] y_pos_o,
  output logic [rwpa_pkg::COORD_BITS-1:0] z_pos_o
);

  logic                           accept;
  logic                           q_push, q_pop;
  rwpa_pkg::q_ctrl_t              q_ctrl;
  rwpa_pkg::step_t                step, head;
  logic                           q_empty;
  logic [rwpa_pkg::QCNT_BITS-1:0] inflight_q, inflight_d;
  rwpa_pkg::coord_t               x_pos, y_pos, z_pos;

  assign accept = in_valid_i && !in_stall_o;

  // queue handshake gathered from front and back
  assign q_ctrl = {q_push, q_pop};

  // requests taken but not yet popped by the back end
  always_comb begin
    inflight_d = inflight_q;
    case ({accept, q_ctrl.pop})
      2'b10:   inflight_d = inflight_q + 1'b1;
      2'b01:   inflight_d = inflight_q - 1'b1;
      default: inflight_d = inflight_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  assign in_stall_o = (inflight_q == rwpa_pkg::QCNT_BITS'(rwpa_pkg::CREDITS));

  // lookup and multiply
  rwpa_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .theta_i   (theta_i),
    .phi_i     (phi_i),
    .restart_i (restart_i),
    .push_o    (q_push),
    .step_o    (step)
  );

  // step queue
  rwpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (q_ctrl),
    .step_i  (step),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // accumulate and present
  rwpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .x_o         (x_pos),
    .y_o         (y_pos),
    .z_o         (z_pos)
  );

  assign x_pos_o = x_pos;
  assign y_pos_o = y_pos;
  assign z_pos_o = z_pos;

endmodule

@@ rtl/rwpa_checker.sv @@
`timescale 1ns / 1ps

module rwpa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [rwpa_pkg::ANGLE_BITS-1:0] theta_i,
  input logic [rwpa_pkg::ANGLE_BITS-1:0] phi_i,
  input logic                            restart_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [rwpa_pkg::COORD_BITS-1:0] x_pos_o,
  input logic [rwpa_pkg::COORD_BITS-1:0] y_pos_o,
  input logic [rwpa_pkg::COORD_BITS-1:0] z_pos_o
);

  // a stalled request stays offered with its fields unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(theta_i) && $stable(phi_i) && $stable(restart_i))
    else $error("request changed while stalled");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its position
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(x_pos_o) && $stable(y_pos_o) && $stable(z_pos_o))
    else $error("position changed while stalled");

  // with an empty output register the queue was drained, so credits remain
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with idle output");

  // reset empties both channels
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("channel active in reset");

endmodule

bind random_walk_position_accumulator rwpa_checker u_rwpa_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // one step request as queued for the driver
  typedef struct packed {
    logic [rwpa_pkg::ANGLE_BITS-1:0] theta;
    logic [rwpa_pkg::ANGLE_BITS-1:0] phi;
    logic                            restart;
  } step_req_t;

  // one predicted position
  typedef struct packed {
    rwpa_pkg::coord_t x;
    rwpa_pkg::coord_t y;
    rwpa_pkg::coord_t z;
  } pos_t;

  localparam longint COORD_HI    = (longint'(1) <<< (rwpa_pkg::COORD_BITS - 1)) - 1;
  localparam longint COORD_LO    = -COORD_HI - 1;
  localparam int     IDLE_PCT    = 38;
  localparam int     HOLD_CYCLES = 300;
  localparam int     PUSH_STEPS  = 20;
  localparam int     MAX_REPORTS = 30;

  // angle codes, fractions of a full turn
  localparam logic [rwpa_pkg::ANGLE_BITS-1:0] TURN_ZERO    = 16'h0000;
  localparam logic [rwpa_pkg::ANGLE_BITS-1:0] TURN_QUARTER = 16'h4000;
  localparam logic [rwpa_pkg::ANGLE_BITS-1:0] TURN_HALF    = 16'h8000;
  localparam logic [rwpa_pkg::ANGLE_BITS-1:0] TURN_3QUART  = 16'hC000;
  localparam logic [rwpa_pkg::ANGLE_BITS-1:0] TURN_EIGHTH  = 16'h2000;
  localparam logic [rwpa_pkg::ANGLE_BITS-1:0] TURN_ALMOST  = 16'hFFFF;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  logic [rwpa_pkg::ANGLE_BITS-1:0] theta_i     = '0;
  logic [rwpa_pkg::ANGLE_BITS-1:0] phi_i       = '0;
  logic                            restart_i   = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [rwpa_pkg::COORD_BITS-1:0] x_pos_o;
  logic [rwpa_pkg::COORD_BITS-1:0] y_pos_o;
  logic [rwpa_pkg::COORD_BITS-1:0] z_pos_o;

  // quarter-wave sine in Q1.15, sin(k*pi/128) for k = 0..64
  int quarter_sine [0:64] = '{
        0,   804,  1608,  2411,  3212,  4011,  4808,  5602,
     6393,  7180,  7962,  8740,  9512, 10279, 11039, 11793,
    12540, 13279, 14010, 14733, 15447, 16151, 16846, 17531,
    18205, 18868, 19520, 20160, 20788, 21403, 22006, 22595,
    23170, 23732, 24279, 24812, 25330, 25833, 26319, 26791,
    27246, 27684, 28106, 28511, 28899, 29269, 29622, 29957,
    30274, 30572, 30853, 31114, 31357, 31581, 31786, 31972,
    32138, 32286, 32413, 32522, 32610, 32679, 32729, 32758,
    32767
  };

  step_req_t pending_steps [$];
  pos_t      due_pos [$];

  // walker position as the predictor sees it
  longint walk_x = 0;
  longint walk_y = 0;
  longint walk_z = 0;

  int err_cnt        = 0;
  int steps_taken    = 0;
  int restarts_taken = 0;
  int clamp_hits     = 0;
  int in_held_cycles = 0;
  int hold_asks      = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  bit src_calm       = 1'b0;
  bit sink_calm      = 1'b0;

  random_walk_position_accumulator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .theta_i     (theta_i),
    .phi_i       (phi_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .x_pos_o     (x_pos_o),
    .y_pos_o     (y_pos_o),
    .z_pos_o     (z_pos_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // full-turn sine from an 8-bit angle: quadrant in the top two bits
  function automatic longint wave(input logic [7:0] a);
    int     k;
    longint v;
    k = a[6] ? 64 - int'(a[5:0]) : int'(a[5:0]);
    v = quarter_sine[k];
    return a[7] ? -v : v;
  endfunction

  // saturating coordinate add
  function automatic longint clamp_add(input longint a, input longint d);
    longint s;
    s = a + d;
    if (s > COORD_HI) begin
      clamp_hits++;
      return COORD_HI;
    end
    if (s < COORD_LO) begin
      clamp_hits++;
      return COORD_LO;
    end
    return s;
  endfunction

  // apply one step to the walker and queue the position it must report
  task automatic advance_walker(input logic [rwpa_pkg::ANGLE_BITS-1:0] theta,
                                input logic [rwpa_pkg::ANGLE_BITS-1:0] phi,
                                input logic restart);
    logic [7:0] t;
    logic [7:0] p;
    longint     st, ct, sp, cp;
    pos_t       want;
    t  = theta[rwpa_pkg::ANGLE_BITS-1 -: 8];
    p  = phi[rwpa_pkg::ANGLE_BITS-1 -: 8];
    st = wave(t);
    ct = wave(t + 8'd64);
    sp = wave(p);
    cp = wave(p + 8'd64);
    if (restart) begin
      walk_x = 0;
      walk_y = 0;
      walk_z = 0;
    end
    walk_x = clamp_add(walk_x, (ct * sp) >>> rwpa_pkg::STEP_SHIFT);
    walk_y = clamp_add(walk_y, (st * sp) >>> rwpa_pkg::STEP_SHIFT);
    walk_z = clamp_add(walk_z, (cp * 32768) >>> rwpa_pkg::STEP_SHIFT);
    want.x = rwpa_pkg::coord_t'(walk_x);
    want.y = rwpa_pkg::coord_t'(walk_y);
    want.z = rwpa_pkg::coord_t'(walk_z);
    due_pos = {due_pos, want};
  endtask

  // compare one coordinate of a result
  task automatic check_coord(input string axis, input rwpa_pkg::coord_t want,
                             input logic [rwpa_pkg::COORD_BITS-1:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, axis, want, $signed(got));
    end
  endtask

  // driver: offer queued requests, idling at random unless calm
  always @(posedge clk_i) begin : drive
    step_req_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_stall_o)
        in_held_cycles++;
      if (in_valid_i && !in_stall_o) begin
        advance_walker(theta_i, phi_i, restart_i);
        steps_taken++;
        if (restart_i)
          restarts_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_steps.size() == 0 ||
            (!src_calm && $urandom_range(99) < IDLE_PCT)) begin
          in_valid_i <= 1'b0;
        end else begin
          req        = pending_steps.pop_front();
          theta_i    <= req.theta;
          phi_i      <= req.phi;
          restart_i  <= req.restart;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // monitor: check results, stall at random or for a long hold-off
  always @(posedge clk_i) begin : observe
    pos_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_pos.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                     $time, $signed(x_pos_o), $signed(y_pos_o), $signed(z_pos_o));
        end else begin
          want = due_pos.pop_front();
          check_coord("x", want.x, x_pos_o);
          check_coord("y", want.y, y_pos_o);
          check_coord("z", want.z, z_pos_o);
        end
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (hold_seen != hold_asks) begin
        hold_seen   <= hold_asks;
        hold_left   <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !sink_calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic queue_step(input logic [rwpa_pkg::ANGLE_BITS-1:0] theta,
                            input logic [rwpa_pkg::ANGLE_BITS-1:0] phi,
                            input logic restart);
    step_req_t req;
    req.theta   = theta;
    req.phi     = phi;
    req.restart = restart;
    pending_steps = {pending_steps, req};
  endtask

  // mostly uniform angles, some close to quadrant boundaries
  function automatic logic [rwpa_pkg::ANGLE_BITS-1:0] rand_angle();
    if ($urandom_range(4) == 0)
      return 16'($urandom_range(3) * 16384 + $urandom_range(511) - 256);
    return 16'($urandom_range(65535));
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++)
      queue_step(rand_angle(), rand_angle(), $urandom_range(19) == 0);
  endtask

  // walk straight along one axis from the origin, then wander
  task automatic queue_push(input logic [rwpa_pkg::ANGLE_BITS-1:0] theta,
                            input logic [rwpa_pkg::ANGLE_BITS-1:0] phi);
    queue_step(theta, phi, 1'b1);
    for (int i = 1; i < PUSH_STEPS; i++)
      queue_step(theta, phi, 1'b0);
    for (int i = 0; i < 10; i++)
      queue_step(rand_angle(), rand_angle(), 1'b0);
  endtask

  task automatic wait_drained();
    while (pending_steps.size() != 0 || in_valid_i || due_pos.size() != 0)
      @(negedge clk_i);
  endtask

  // reset and stimulus
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: angle extremes, quadrant edges, table end, truncated bits, restart
    queue_step(TURN_ZERO, TURN_ZERO, 1'b1);
    queue_step(TURN_ZERO, TURN_ALMOST, 1'b0);
    queue_step(TURN_ALMOST, TURN_ALMOST, 1'b0);
    queue_step(16'h00FF, 16'h00FF, 1'b0);
    queue_step(TURN_QUARTER, TURN_QUARTER, 1'b0);
    queue_step(TURN_HALF, TURN_QUARTER, 1'b0);
    queue_step(TURN_3QUART, TURN_QUARTER, 1'b0);
    queue_step(TURN_ZERO, TURN_HALF, 1'b0);
    queue_step(TURN_ZERO, TURN_3QUART, 1'b0);
    queue_step(16'h3FFF, 16'h7FFF, 1'b0);
    queue_step(16'hBFFF, 16'hC0FF, 1'b0);
    queue_step(TURN_EIGHTH, TURN_EIGHTH, 1'b0);
    queue_step(16'h5555, 16'hAAAA, 1'b0);
    queue_step(16'hAAAA, 16'h5555, 1'b1);
    queue_step(16'hFF00, 16'h00FF, 1'b1);
    queue_step(TURN_HALF, TURN_HALF, 1'b1);
    queue_step(16'h40FF, 16'hC000, 1'b0);
    queue_step(16'h7F00, 16'h8100, 1'b0);
    queue_step(TURN_ALMOST, TURN_ZERO, 1'b1);
    queue_step(TURN_ZERO, TURN_ZERO, 1'b0);

    // sender pauses until every result is back
    wait_drained();
    repeat (10) @(negedge clk_i);

    queue_random(500);
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    src_calm = 1'b1;
    hold_asks++;
    queue_random(120);
    wait_drained();

    // stretch with no idling on either side
    sink_calm = 1'b1;
    queue_random(300);
    wait_drained();

    // straight runs along each axis
    queue_push(TURN_ZERO, TURN_QUARTER);
    queue_push(TURN_3QUART, TURN_QUARTER);
    queue_push(TURN_ZERO, TURN_ZERO);
    queue_push(TURN_ZERO, TURN_HALF);
    wait_drained();

    src_calm  = 1'b0;
    sink_calm = 1'b0;
    queue_random(450);
    wait_drained();
    repeat (20) @(negedge clk_i);

    $display("covered %0d steps, %0d with restart, %0d clamped coordinates",
             steps_taken, restarts_taken, clamp_hits);
    $display("input held off for %0d cycles under output back-pressure",
             in_held_cycles);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rwpa_pkg.sv
rtl/rwpa_front.sv
rtl/rwpa_queue.sv
rtl/rwpa_back.sv
rtl/random_walk_position_accumulator.sv
rtl/rwpa_checker.sv
bench/tb.sv
